FILE: hw/rtl/clhm_pkg.sv
package clhm_pkg;

  localparam int NCAT = 4;
  localparam int IDX_IDLE = 3;
  localparam int CNT_W = 64;
  localparam int SHARE_W = 14;
  localparam int PROD_W = CNT_W + SHARE_W;
  localparam int STEP_W = $clog2(SHARE_W);
  localparam int PCT_W = 8;

  localparam logic [SHARE_W-1:0] BP_FULL = 14'd10000;
  localparam logic [SHARE_W-1:0] BP_PER_PCT = 14'd100;
  localparam logic [PCT_W-1:0] PCT_MIN_LO = 8'd1;
  localparam logic [PCT_W-1:0] PCT_MIN_HI = 8'd99;
  localparam logic [PCT_W-1:0] PCT_REC_HI = 8'd100;

  localparam int COOL_SAMPLES = 3;
  localparam int COOL_W = $clog2(COOL_SAMPLES + 1);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_RECOVER = 2'd1;
  localparam logic [PCT_W-1:0] IDLE_MIN_RESET = 8'd20;
  localparam logic [PCT_W-1:0] IDLE_RECOVER_RESET = 8'd40;

  typedef logic [NCAT-1:0][SHARE_W-1:0] share_vec_t;
  typedef logic [NCAT-1:0][CNT_W-1:0] cnt_vec_t;

  typedef struct packed {
    logic             cpu_is_online;
    logic [CNT_W-1:0] total_time;
    logic [CNT_W-1:0] system_time;
    logic [CNT_W-1:0] softirq_time;
    logic [CNT_W-1:0] irq_time;
    logic [CNT_W-1:0] idle_time;
  } in_word_t;

  typedef struct packed {
    logic [SHARE_W-1:0] system_share_now;
    logic [SHARE_W-1:0] system_share_avg;
    logic [SHARE_W-1:0] softirq_share_now;
    logic [SHARE_W-1:0] softirq_share_avg;
    logic [SHARE_W-1:0] irq_share_now;
    logic [SHARE_W-1:0] irq_share_avg;
    logic [SHARE_W-1:0] idle_share_now;
    logic [SHARE_W-1:0] idle_share_avg;
    logic               core_blocked;
  } out_word_t;

  typedef struct packed {
    logic update;
    logic offline;
  } merge_ctl_t;

endpackage

FILE: hw/rtl/clhm_lane.sv
module clhm_lane
  import clhm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [CNT_W-1:0]   d,
  input  logic [CNT_W-1:0]   dt,
  output logic               done,
  output logic [SHARE_W-1:0] share
);

  logic               busy;
  logic               div_phase;
  logic [STEP_W-1:0]  cnt;
  logic               sat;
  logic [CNT_W-1:0]   dv;
  logic [CNT_W-1:0]   dtv;
  logic [PROD_W-1:0]  n;
  logic [CNT_W-1:0]   r;
  logic [SHARE_W-1:0] lo;
  logic [SHARE_W-1:0] q;

  logic               last;
  logic [STEP_W-1:0]  bit_sel;
  logic [PROD_W-1:0]  mul_sum;
  logic [CNT_W:0]     trial;
  logic [CNT_W:0]     diff;
  logic               ge;

  assign last    = (cnt == STEP_W'(SHARE_W - 1));
  assign bit_sel = STEP_W'(SHARE_W - 1) - cnt;

  // d * 10000 built msb first, one bit of the constant per cycle
  assign mul_sum = {n[PROD_W-2:0], 1'b0} +
                   (BP_FULL[bit_sel] ? {{SHARE_W{1'b0}}, dv} : {PROD_W{1'b0}});

  // restoring step: remainder stays below dt, quotient fits 14 bits
  assign trial = {r, lo[SHARE_W-1]};
  assign ge    = (trial >= {1'b0, dtv});
  assign diff  = trial - {1'b0, dtv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      div_phase <= 1'b0;
      cnt       <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        div_phase <= 1'b0;
        cnt       <= '0;
      end else if (busy) begin
        if (last) begin
          cnt <= '0;
          if (div_phase) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
          div_phase <= ~div_phase;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dv  <= d;
      dtv <= dt;
      sat <= (d >= dt);
      n   <= '0;
    end else if (busy && !div_phase) begin
      n <= mul_sum;
      if (last) begin
        r  <= mul_sum[PROD_W-1:SHARE_W];
        lo <= mul_sum[SHARE_W-1:0];
      end
    end else if (busy) begin
      r  <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      lo <= {lo[SHARE_W-2:0], 1'b0};
      q  <= {q[SHARE_W-2:0], ge};
    end
  end

  assign share = sat ? BP_FULL : q;

endmodule

FILE: hw/rtl/clhm_merge.sv
module clhm_merge
  import clhm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  merge_ctl_t       ctl,
  input  share_vec_t       share_new,
  input  logic [PCT_W-1:0] floor_pct,
  input  logic [PCT_W-1:0] release_pct,
  output share_vec_t       share_now,
  output share_vec_t       share_avg,
  output logic             blocked,
  output logic [COOL_W-1:0] cool
);

  share_vec_t         avg_new;
  logic [PCT_W-1:0]   minp;
  logic [PCT_W-1:0]   rec_lo;
  logic [PCT_W-1:0]   recp;
  logic [SHARE_W-1:0] min_bp;
  logic [SHARE_W-1:0] rec_bp;
  logic               low;
  logic               recovered;
  logic [COOL_W-1:0]  cool_inc;
  logic [SHARE_W+1:0] wsum [NCAT];

  // (3*old + new) / 4, or new when old is zero
  always_comb begin
    for (int i = 0; i < NCAT; i++) begin
      wsum[i] = {2'b00, share_avg[i]} + {1'b0, share_avg[i], 1'b0} +
                {2'b00, share_new[i]};
      avg_new[i] = (share_avg[i] != '0) ? wsum[i][SHARE_W+1:2] : share_new[i];
    end
  end

  always_comb begin
    minp = floor_pct;
    if (minp < PCT_MIN_LO) minp = PCT_MIN_LO;
    if (minp > PCT_MIN_HI) minp = PCT_MIN_HI;
    rec_lo = minp + 1'b1;
    recp = release_pct;
    if (recp < rec_lo) recp = rec_lo;
    if (recp > PCT_REC_HI) recp = PCT_REC_HI;
    min_bp = {{(SHARE_W-PCT_W){1'b0}}, minp} * BP_PER_PCT;
    rec_bp = {{(SHARE_W-PCT_W){1'b0}}, recp} * BP_PER_PCT;
  end

  assign low       = (share_new[IDX_IDLE] < min_bp) || (avg_new[IDX_IDLE] < min_bp);
  assign recovered = (share_new[IDX_IDLE] >= rec_bp) && (avg_new[IDX_IDLE] >= rec_bp);
  assign cool_inc  = cool + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NCAT; i++) begin
        share_now[i] <= (i == IDX_IDLE) ? BP_FULL : '0;
        share_avg[i] <= (i == IDX_IDLE) ? BP_FULL : '0;
      end
      blocked <= 1'b0;
      cool    <= '0;
    end else if (ctl.update) begin
      if (ctl.offline) begin
        blocked <= 1'b1;
        cool    <= '0;
      end else begin
        share_now <= share_new;
        share_avg <= avg_new;
        if (low) begin
          blocked <= 1'b1;
          cool    <= '0;
        end else if (blocked) begin
          if (recovered) begin
            if (cool_inc >= COOL_W'(COOL_SAMPLES)) begin
              blocked <= 1'b0;
              cool    <= '0;
            end else begin
              cool <= cool_inc;
            end
          end else begin
            cool <= '0;
          end
        end
      end
    end
  end

endmodule

FILE: hw/rtl/cpu_load_hysteresis_monitor_unit.sv
// Per-core load monitor. Each input word is one sample of five cumulative time
// counters and an online flag; each accepted word yields exactly one output word
// with the current and smoothed system, softirq, irq and idle shares (basis
// points) and the core_blocked flag. The first online sample after reset only
// primes the stored counters, a sample with an unchanged total only refreshes
// them, and an offline sample blocks at once. A sample that computes shares
// goes from acceptance to output valid thus: the start state starts the lanes
// on the registered deltas; four division lanes in lockstep each form delta*10000
// and then run a one-bit-per-cycle restoring divide by the total delta; the wait
// state sees the lanes finish; the merge state updates the shares; the output
// register loads. Priming and unchanged-total samples go straight to the output
// load, offline samples through the merge state first. A word still waiting on
// out_ready adds its wait to the next sample. One sample is in flight at a
// time; the output register holds a finished word while the next sample is
// accepted. Config writes are always accepted; the thresholds are read in the
// merge step, so write them only while no sample is in flight.
module cpu_load_hysteresis_monitor_unit
  import clhm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PCT_W-1:0]     cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_WAIT  = 3'd2;
  localparam logic [2:0] ST_MERGE = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]        state;
  logic [PCT_W-1:0]  floor_pct;
  logic [PCT_W-1:0]  release_pct;
  logic              primed;
  logic              online;
  logic [CNT_W-1:0]  prev_total;
  cnt_vec_t          prev_cnt;
  cnt_vec_t          cur_cnt;
  cnt_vec_t          delta;
  logic [CNT_W-1:0]  tot_delta;
  logic [NCAT-1:0]   lane_done;
  share_vec_t        lane_share;
  merge_ctl_t        mctl;
  share_vec_t        share_now;
  share_vec_t        share_avg;
  logic              blocked;
  logic [COOL_W-1:0] cool;
  logic              in_acc;
  logic              out_load;

  assign cur_cnt   = {in_data.idle_time, in_data.irq_time,
                      in_data.softirq_time, in_data.system_time};
  assign in_ready  = (state == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_load  = (state == ST_DONE) && (!out_valid || out_ready);

  assign mctl.update  = (state == ST_MERGE);
  assign mctl.offline = !online;

  always_ff @(posedge clk) begin
    if (rst) begin
      floor_pct   <= IDLE_MIN_RESET;
      release_pct <= IDLE_RECOVER_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IDLE_MIN:     floor_pct   <= cfg_data;
        REG_IDLE_RECOVER: release_pct <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      primed     <= 1'b0;
      online     <= 1'b0;
      prev_total <= '0;
      prev_cnt   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            online <= in_data.cpu_is_online;
            if (!in_data.cpu_is_online) begin
              state <= ST_MERGE;
            end else begin
              prev_total <= in_data.total_time;
              prev_cnt   <= cur_cnt;
              if (!primed) begin
                primed <= 1'b1;
                state  <= ST_DONE;
              end else if (in_data.total_time == prev_total) begin
                state <= ST_DONE;
              end else begin
                state <= ST_START;
              end
            end
          end
        end
        ST_START: state <= ST_WAIT;
        ST_WAIT:  if (&lane_done) state <= ST_MERGE;
        ST_MERGE: state <= ST_DONE;
        ST_DONE:  if (out_load) state <= ST_IDLE;
        default:  state <= ST_IDLE;
      endcase
    end
  end

  // deltas wrap modulo 2^64
  always_ff @(posedge clk) begin
    if (in_acc) begin
      tot_delta <= in_data.total_time - prev_total;
      for (int i = 0; i < NCAT; i++) begin
        delta[i] <= cur_cnt[i] - prev_cnt[i];
      end
    end
  end

  for (genvar g = 0; g < NCAT; g++) begin : g_lane
    clhm_lane u_lane (
      .clk   (clk),
      .rst   (rst),
      .start (state == ST_START),
      .d     (delta[g]),
      .dt    (tot_delta),
      .done  (lane_done[g]),
      .share (lane_share[g])
    );
  end

  clhm_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .ctl         (mctl),
    .share_new   (lane_share),
    .floor_pct   (floor_pct),
    .release_pct (release_pct),
    .share_now   (share_now),
    .share_avg   (share_avg),
    .blocked     (blocked),
    .cool        (cool)
  );

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.system_share_now  <= share_now[0];
      out_data.system_share_avg  <= share_avg[0];
      out_data.softirq_share_now <= share_now[1];
      out_data.softirq_share_avg <= share_avg[1];
      out_data.irq_share_now     <= share_now[2];
      out_data.irq_share_avg     <= share_avg[2];
      out_data.idle_share_now    <= share_now[IDX_IDLE];
      out_data.idle_share_avg    <= share_avg[IDX_IDLE];
      out_data.core_blocked      <= blocked;
    end
  end

`ifndef SYNTHESIS
  // lanes start together and must finish together
  a_lane_lockstep: assert property (@(posedge clk) disable iff (rst)
    (|lane_done) |-> (&lane_done))
    else $error("division lanes out of step");

  a_offline_blocks: assert property (@(posedge clk) disable iff (rst)
    (mctl.update && mctl.offline) |=> blocked)
    else $error("offline sample did not block the core");

  a_cool_range: assert property (@(posedge clk) disable iff (rst)
    cool < COOL_W'(COOL_SAMPLES))
    else $error("cool counter past its limit");

  a_avg_bound: assert property (@(posedge clk) disable iff (rst)
    share_avg[IDX_IDLE] <= BP_FULL)
    else $error("smoothed idle share above full scale");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("output word raised outside completion");
`endif

endmodule

FILE: bench/testbench.sv
module testbench;
  import clhm_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_CYCLES = 64;
  localparam int PHASES = 9;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int MIN_SET [PHASES] = '{20, 0, 255, 50, 10, 1, 99, 35, 0};
  localparam int REC_SET [PHASES] = '{40, 0, 255, 30, 90, 2, 100, 36, 0};

  localparam out_word_t BLOCKED_AT_RESET = '{14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0,
                                             BP_FULL, BP_FULL, 1'b1};
  localparam out_word_t FIRST_SHARES = '{14'd1000, 14'd1000, 14'd500, 14'd500,
                                         14'd500, 14'd500, 14'd8000, 14'd9500, 1'b1};

  typedef enum {PACE_FREE, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_t;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [PCT_W-1:0]     reg_val;
    in_word_t             smp;
    bit                   has_exp;
    out_word_t            exp;
  } dir_row_t;

  typedef logic [SHARE_W-1:0] view_fields_t [9];

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_word_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_word_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PCT_W-1:0]     cfg_data = '0;

  cpu_load_hysteresis_monitor_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor copy of the block state
  logic [PCT_W-1:0]   min_pct = IDLE_MIN_RESET;
  logic [PCT_W-1:0]   rec_pct = IDLE_RECOVER_RESET;
  bit                 primed_seen = 1'b0;
  logic [CNT_W-1:0]   last_cnt [5] = '{default: '0};
  logic [SHARE_W-1:0] now_bp [NCAT] = '{14'd0, 14'd0, 14'd0, BP_FULL};
  logic [SHARE_W-1:0] avg_bp [NCAT] = '{14'd0, 14'd0, 14'd0, BP_FULL};
  bit                 barred = 1'b0;
  int                 cool_run = 0;

  out_word_t expected_views [$];
  int        fail_count = 0;
  int        reported = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  // sample generator state
  logic [CNT_W-1:0] gen_cnt [5] = '{default: '0};
  int               regime = 0;
  int               regime_left = 0;

  string field_names [9] = '{"system_share_now", "system_share_avg", "softirq_share_now",
                             "softirq_share_avg", "irq_share_now", "irq_share_avg",
                             "idle_share_now", "idle_share_avg", "core_blocked"};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [SHARE_W-1:0] bp_share(logic [CNT_W-1:0] d, logic [CNT_W-1:0] dt);
    logic [PROD_W-1:0] prod;
    if (d >= dt) return BP_FULL;
    prod = {{SHARE_W{1'b0}}, d} * PROD_W'(10000);
    return SHARE_W'(prod / {{SHARE_W{1'b0}}, dt});
  endfunction

  function automatic void idle_limits(output int lo_bp, output int hi_bp);
    int mp;
    int rp;
    mp = int'(min_pct);
    if (mp < int'(PCT_MIN_LO)) mp = int'(PCT_MIN_LO);
    if (mp > int'(PCT_MIN_HI)) mp = int'(PCT_MIN_HI);
    rp = int'(rec_pct);
    if (rp < mp + 1) rp = mp + 1;
    if (rp > int'(PCT_REC_HI)) rp = int'(PCT_REC_HI);
    lo_bp = mp * int'(BP_PER_PCT);
    hi_bp = rp * int'(BP_PER_PCT);
  endfunction

  function automatic out_word_t predict_view(in_word_t w);
    logic [CNT_W-1:0]   dt;
    logic [CNT_W-1:0]   d [NCAT];
    logic [SHARE_W-1:0] r;
    int                 lo_bp;
    int                 hi_bp;
    out_word_t          v;
    if (!w.cpu_is_online) begin
      barred = 1'b1;
      cool_run = 0;
    end else begin
      dt   = w.total_time - last_cnt[0];
      d[0] = w.system_time - last_cnt[1];
      d[1] = w.softirq_time - last_cnt[2];
      d[2] = w.irq_time - last_cnt[3];
      d[3] = w.idle_time - last_cnt[4];
      last_cnt = '{w.total_time, w.system_time, w.softirq_time, w.irq_time, w.idle_time};
      if (!primed_seen) begin
        primed_seen = 1'b1;
      end else if (dt != '0) begin
        for (int k = 0; k < NCAT; k++) begin
          r = bp_share(d[k], dt);
          if (avg_bp[k] != '0) avg_bp[k] = SHARE_W'((int'(avg_bp[k]) * 3 + int'(r)) / 4);
          else avg_bp[k] = r;
          now_bp[k] = r;
        end
        idle_limits(lo_bp, hi_bp);
        if (int'(now_bp[IDX_IDLE]) < lo_bp || int'(avg_bp[IDX_IDLE]) < lo_bp) begin
          barred = 1'b1;
          cool_run = 0;
        end else if (barred) begin
          if (int'(now_bp[IDX_IDLE]) >= hi_bp && int'(avg_bp[IDX_IDLE]) >= hi_bp) begin
            cool_run++;
            if (cool_run >= COOL_SAMPLES) begin
              barred = 1'b0;
              cool_run = 0;
            end
          end else begin
            cool_run = 0;
          end
        end
      end
    end
    v.system_share_now  = now_bp[0];
    v.system_share_avg  = avg_bp[0];
    v.softirq_share_now = now_bp[1];
    v.softirq_share_avg = avg_bp[1];
    v.irq_share_now     = now_bp[2];
    v.irq_share_avg     = avg_bp[2];
    v.idle_share_now    = now_bp[3];
    v.idle_share_avg    = avg_bp[3];
    v.core_blocked      = barred;
    return v;
  endfunction

  function automatic view_fields_t view_fields(out_word_t v);
    view_fields_t f;
    f[0] = v.system_share_now;
    f[1] = v.system_share_avg;
    f[2] = v.softirq_share_now;
    f[3] = v.softirq_share_avg;
    f[4] = v.irq_share_now;
    f[5] = v.irq_share_avg;
    f[6] = v.idle_share_now;
    f[7] = v.idle_share_avg;
    f[8] = {{(SHARE_W-1){1'b0}}, v.core_blocked};
    return f;
  endfunction

  function automatic logic [CNT_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [CNT_W-1:0] scale_bp(logic [CNT_W-1:0] x, int bp);
    logic [PROD_W-1:0] p;
    p = {{SHARE_W{1'b0}}, x} * PROD_W'(bp);
    return CNT_W'(p / PROD_W'(10000));
  endfunction

  // mostly well-formed counter sequences, the idle share held in one band for a few words
  function automatic in_word_t make_sample();
    in_word_t         w;
    int               pick;
    int               width;
    int               idle_bp;
    int               lo_bp;
    int               hi_bp;
    logic [CNT_W-1:0] dt;
    logic [CNT_W-1:0] rem;
    logic [CNT_W-1:0] dd [NCAT];
    pick = $urandom_range(0, 99);
    if (regime_left == 0) begin
      regime = $urandom_range(0, 9);
      regime_left = $urandom_range(3, 12);
    end
    regime_left--;
    if (pick < 4) begin
      w = {1'b0, rand64(), rand64(), rand64(), rand64(), rand64()};
      return w;
    end
    if (pick < 8) begin
      for (int k = 0; k < 5; k++) gen_cnt[k] = rand64();
    end else begin
      width = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(20, 64);
      dt = rand64() >> (64 - width);
      if (dt == '0) dt = 64'd1;
      if (pick < 12) dt = '0;
      idle_limits(lo_bp, hi_bp);
      case (regime)
        0, 1:    idle_bp = $urandom_range(0, lo_bp - 1);
        2, 3:    idle_bp = $urandom_range(lo_bp, hi_bp - 1);
        4, 5, 6, 7: idle_bp = $urandom_range(hi_bp, 10000);
        default: idle_bp = $urandom_range(0, 10000);
      endcase
      if (dt == '0) begin
        for (int k = 0; k < NCAT; k++) dd[k] = CNT_W'($urandom_range(0, 1000));
      end else begin
        dd[3] = scale_bp(dt, idle_bp);
        rem = dt - dd[3];
        dd[0] = scale_bp(rem, $urandom_range(0, 10000));
        rem = rem - dd[0];
        dd[1] = scale_bp(rem, $urandom_range(0, 10000));
        rem = rem - dd[1];
        dd[2] = scale_bp(rem, $urandom_range(0, 10000));
        // a category running ahead of the total saturates
        if ($urandom_range(0, 19) == 0) dd[$urandom_range(0, 3)] = dt + CNT_W'($urandom_range(1, 1000));
      end
      gen_cnt[0] = gen_cnt[0] + dt;
      for (int k = 0; k < NCAT; k++) gen_cnt[k+1] = gen_cnt[k+1] + dd[k];
    end
    w = {1'b1, gen_cnt[0], gen_cnt[1], gen_cnt[2], gen_cnt[3], gen_cnt[4]};
    return w;
  endfunction

  function automatic in_word_t sample_word(bit on, logic [CNT_W-1:0] t, logic [CNT_W-1:0] s,
                                           logic [CNT_W-1:0] so, logic [CNT_W-1:0] iq,
                                           logic [CNT_W-1:0] id);
    in_word_t w;
    w = {on, t, s, so, iq, id};
    return w;
  endfunction

  function automatic dir_row_t smp_row(in_word_t w);
    dir_row_t r;
    r = '{1'b0, '0, '0, w, 1'b0, '0};
    return r;
  endfunction

  function automatic dir_row_t checked_row(in_word_t w, out_word_t e);
    dir_row_t r;
    r = '{1'b0, '0, '0, w, 1'b1, e};
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [PCT_W-1:0] val);
    dir_row_t r;
    r = '{1'b1, idx, val, '0, 1'b0, '0};
    return r;
  endfunction

  function automatic void set_pace(pace_t p);
    case (p)
      PACE_FREE: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      PACE_SEND_IDLE: begin
        send_idle_pct = 86;
        recv_stall_pct = 0;
      end
      PACE_RECV_STALL: begin
        send_idle_pct = 0;
        recv_stall_pct = 86;
      end
      default: begin
        send_idle_pct = 34;
        recv_stall_pct = 34;
      end
    endcase
  endfunction

  task automatic send_sample(in_word_t w, bit typed, out_word_t typed_view);
    out_word_t predicted;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    predicted = predict_view(w);
    expected_views.push_back(typed ? typed_view : predicted);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PCT_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_IDLE_MIN) min_pct = val;
    else if (idx == REG_IDLE_RECOVER) rec_pct = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : sink_pacing
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin : result_check
    out_word_t    want;
    view_fields_t fw;
    view_fields_t fg;
    bit           bad;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (expected_views.size() == 0) begin
          if (reported < 10) $display("unexpected output word, nothing pending: %h", out_data);
          reported++;
          fail_count++;
        end else begin
          want = expected_views.pop_front();
          fw = view_fields(want);
          fg = view_fields(out_data);
          bad = 1'b0;
          for (int k = 0; k < 9; k++) begin
            if (fw[k] !== fg[k]) begin
              bad = 1'b1;
              if (reported < 10)
                $display("mismatch %s: expected %0d, got %0d", field_names[k], fw[k], fg[k]);
            end
          end
          if (bad) begin
            reported++;
            fail_count++;
          end
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("** cpu_load_hysteresis_monitor_unit: FAILED **");
    $finish;
  end

  initial begin : stimulus
    dir_row_t dir_rows [$];
    int       ph;
    int       n;
    // offline first word, then priming, then a few recovery words
    dir_rows.push_back(checked_row(sample_word(1'b0, '1, '1, '1, '1, '1), BLOCKED_AT_RESET));
    dir_rows.push_back(checked_row(sample_word(1'b1, 64'd100, 0, 0, 0, 0), BLOCKED_AT_RESET));
    dir_rows.push_back(checked_row(sample_word(1'b1, 64'd200, 64'd10, 64'd5, 64'd5, 64'd80),
                                   FIRST_SHARES));
    dir_rows.push_back(smp_row(sample_word(1'b1, 64'd300, 64'd20, 64'd10, 64'd10, 64'd160)));
    dir_rows.push_back(smp_row(sample_word(1'b1, 64'd400, 64'd30, 64'd15, 64'd15, 64'd240)));
    // unchanged total only refreshes the counters
    dir_rows.push_back(smp_row(sample_word(1'b1, 64'd400, 64'd35, 64'd16, 64'd17, 64'd300)));
    dir_rows.push_back(smp_row(sample_word(1'b1, 64'd401, 64'd36, 64'd16, 64'd17, 64'd300)));
    // softirq delta above the total delta
    dir_rows.push_back(smp_row(sample_word(1'b1, 64'd411, 64'd36, 64'd66, 64'd17, 64'd305)));
    dir_rows.push_back(smp_row(sample_word(1'b1, 64'hFFFF_FFFF_FFFF_FF00, 64'd36, 64'd66,
                                           64'd17, 64'hFFFF_FFFF_FFFF_FC00)));
    // counters wrap past zero
    dir_rows.push_back(smp_row(sample_word(1'b1, 64'd100, 64'd36, 64'd66, 64'd17, 64'd50)));
    // largest total delta
    dir_rows.push_back(smp_row(sample_word(1'b1, 64'd99, 64'd37, 64'd66, 64'd17, 64'd48)));
    dir_rows.push_back(smp_row(sample_word(1'b1, 0, 0, 0, 0, 0)));
    dir_rows.push_back(smp_row(sample_word(1'b1, '1, '1, '1, '1, '1)));
    dir_rows.push_back(cfg_row(REG_IDLE_MIN, 8'd0));
    dir_rows.push_back(cfg_row(REG_IDLE_RECOVER, 8'd0));
    dir_rows.push_back(smp_row(sample_word(1'b1, 64'd99, 64'd9, '1, 64'd4, 64'd1)));
    dir_rows.push_back(smp_row(sample_word(1'b1, 64'd199, 64'd9, '1, 64'd4, 64'd1)));
    dir_rows.push_back(cfg_row(REG_IDLE_MIN, 8'd255));
    dir_rows.push_back(cfg_row(REG_IDLE_RECOVER, 8'd255));
    dir_rows.push_back(smp_row(sample_word(1'b1, 64'd299, 64'd9, '1, 64'd4, 64'd101)));
    dir_rows.push_back(smp_row(sample_word(1'b1, 64'd399, 64'd9, '1, 64'd4, 64'd201)));
    dir_rows.push_back(smp_row(sample_word(1'b1, 64'd499, 64'd9, '1, 64'd4, 64'd301)));
    dir_rows.push_back(smp_row(sample_word(1'b1, 64'd599, 64'd9, '1, 64'd4, 64'd401)));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        wait_drained();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        send_sample(dir_rows[i].smp, dir_rows[i].has_exp, dir_rows[i].exp);
      end
    end

    for (ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      if (ph == PHASES - 1) begin
        write_reg(REG_IDLE_MIN, PCT_W'($urandom_range(0, 255)));
        write_reg(REG_IDLE_RECOVER, PCT_W'($urandom_range(0, 255)));
      end else begin
        write_reg(REG_IDLE_MIN, PCT_W'(MIN_SET[ph]));
        write_reg(REG_IDLE_RECOVER, PCT_W'(REC_SET[ph]));
      end
      set_pace(pace_t'(ph % 4));
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // hold the sender back until the block has emptied
        if (n == ITEMS_PER_PHASE / 2) wait_drained();
        send_sample(make_sample(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("** cpu_load_hysteresis_monitor_unit: PASSED **");
    else
      $display("** cpu_load_hysteresis_monitor_unit: FAILED **");
    $finish;
  end

endmodule

FILE: cpu_load_hysteresis_monitor_unit.f
hw/rtl/clhm_pkg.sv
hw/rtl/clhm_lane.sv
hw/rtl/clhm_merge.sv
hw/rtl/cpu_load_hysteresis_monitor_unit.sv
bench/testbench.sv
